/* hw/rtl/stc_pkg.sv */
// stc_pkg: constants, types and helpers shared by the trim compensation block.
// No dependencies.
`default_nettype none
package stc_pkg;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CAL_TEMP    = 3'd0,
    REG_CAL_PRESS_A = 3'd1,
    REG_CAL_PRESS_B = 3'd2,
    REG_CAL_PRESS_C = 3'd3,
    REG_CAL_HUM_A   = 3'd4,
    REG_CAL_HUM_B   = 3'd5
  } reg_idx_e;

  localparam logic [31:0] HumMax = 32'd419430400;

  // trim coefficients, each widened to 32 bits as the formulas use them
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } trim_t;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic [31:0]        pressure;
    logic [16:0]        humidity;
  } out_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
    return a * b;
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/stc_stream_if.sv */
// stc_stream_if: valid/ready channel carrying one word of type T.
// No dependencies; the payload type is set by parameter T.
`default_nettype none
interface stc_stream_if #(parameter type T = logic) (input wire logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sensor_trim_compensation.sv */
// Trim compensation for temperature, pressure and humidity readings.
// Input channel in_if: one word of raw readings (temperature, pressure,
// humidity). Output channel out_if: one word of compensated temperature
// (0.01 degC), pressure (Pa, 0 on zero divisor) and humidity (Q7.10 %).
// Config port: cfg_we_i, cfg_idx_i, cfg_data_i write one trim register per
// edge; write only while the block is idle.
// Pipeline: 12 arithmetic stages, 32 stages of the restoring divider
// (one quotient bit each), 3 stages after.
// Throughput: one word per cycle while the receiver does not stall.
// The pipeline advances as a whole whenever its last stage is empty or the
// receiver takes the word; a receiver stall freezes every stage, so in_if
// ready drops with it and nothing is lost or repeated.
// Reset clears all valid bits and the trim registers to zero.
// Depends on stc_pkg, stc_stream_if, stc_cfg_regs, stc_datapath.
`default_nettype none
module sensor_trim_compensation (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [stc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [stc_pkg::CfgW-1:0]    cfg_data_i,
  stc_stream_if.sink                       in_if,
  stc_stream_if.source                     out_if
);
  import stc_pkg::*;

  trim_t trim;
  logic  en;

  stc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .trim_o(trim)
  );

  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  stc_datapath u_dp (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_if.valid), .in_i(in_if.data), .trim_i(trim),
    .valid_o(out_if.valid), .out_o(out_if.data)
  );
endmodule
`default_nettype wire

/* hw/rtl/stc_cfg_regs.sv */
// stc_cfg_regs: trim register file, unpacks coefficients.
// Depends on stc_pkg.
`default_nettype none
module stc_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [stc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [stc_pkg::CfgW-1:0]      cfg_data_i,
  output stc_pkg::trim_t                     trim_o
);
  import stc_pkg::*;

  logic [47:0] cal_temp_q;
  logic [63:0] cal_press_a_q, cal_press_b_q;
  logic [15:0] cal_press_c_q;
  logic [39:0] cal_hum_a_q;
  logic [31:0] cal_hum_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q    <= '0;
      cal_press_a_q <= '0;
      cal_press_b_q <= '0;
      cal_press_c_q <= '0;
      cal_hum_a_q   <= '0;
      cal_hum_b_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CAL_TEMP:    cal_temp_q    <= cfg_data_i[47:0];
        REG_CAL_PRESS_A: cal_press_a_q <= cfg_data_i;
        REG_CAL_PRESS_B: cal_press_b_q <= cfg_data_i;
        REG_CAL_PRESS_C: cal_press_c_q <= cfg_data_i[15:0];
        REG_CAL_HUM_A:   cal_hum_a_q   <= cfg_data_i[39:0];
        REG_CAL_HUM_B:   cal_hum_b_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    trim_o.t1 = {16'd0, cal_temp_q[15:0]};
    trim_o.t2 = sx16(cal_temp_q[31:16]);
    trim_o.t3 = sx16(cal_temp_q[47:32]);
    trim_o.p1 = {16'd0, cal_press_a_q[15:0]};
    trim_o.p2 = sx16(cal_press_a_q[31:16]);
    trim_o.p3 = sx16(cal_press_a_q[47:32]);
    trim_o.p4 = sx16(cal_press_a_q[63:48]);
    trim_o.p5 = sx16(cal_press_b_q[15:0]);
    trim_o.p6 = sx16(cal_press_b_q[31:16]);
    trim_o.p7 = sx16(cal_press_b_q[47:32]);
    trim_o.p8 = sx16(cal_press_b_q[63:48]);
    trim_o.p9 = sx16(cal_press_c_q);
    trim_o.h1 = {24'd0, cal_hum_a_q[7:0]};
    trim_o.h2 = sx16(cal_hum_a_q[23:8]);
    trim_o.h3 = {24'd0, cal_hum_a_q[31:24]};
    trim_o.h6 = sx8(cal_hum_a_q[39:32]);
    trim_o.h4 = sx16(cal_hum_b_q[15:0]);
    trim_o.h5 = sx16(cal_hum_b_q[31:16]);
  end
endmodule
`default_nettype wire

/* hw/rtl/stc_divider.sv */
// stc_divider: pipelined 32/32 unsigned restoring divider, one quotient bit
// per stage, with payload carried alongside. Depends on stc_pkg.
`default_nettype none
module stc_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [31:0]       num_i,
  input  wire logic [31:0]       den_i,
  input  wire logic              dbl_i,    // 1: quotient times two afterward
  input  wire logic              zero_i,   // divisor was zero
  input  wire stc_pkg::out_t     side_i,
  output logic                   valid_o,
  output logic [31:0]            quo_o,
  output logic                   dbl_o,
  output logic                   zero_o,
  output stc_pkg::out_t          side_o
);
  import stc_pkg::*;

  localparam int unsigned N = 32;

  // stage s holds remainder and quotient after s+1 bits
  logic [N-1:0]    vld_q, dbl_q, zero_q;
  logic [31:0]     rem_q [N];
  logic [31:0]     num_q [N];
  logic [31:0]     den_q [N];
  out_t            side_q [N];

  // stage inputs
  logic [N-1:0]    vld_in, dbl_in, zero_in;
  logic [31:0]     rem_in [N];
  logic [31:0]     num_in [N];
  logic [31:0]     den_in [N];
  out_t            side_in [N];
  logic [32:0]     shifted [N];
  logic [32:0]     trial [N];

  always_comb begin
    vld_in[0]  = valid_i;
    rem_in[0]  = '0;
    num_in[0]  = num_i;
    den_in[0]  = den_i;
    dbl_in[0]  = dbl_i;
    zero_in[0] = zero_i;
    side_in[0] = side_i;
    for (int s = 1; s < N; s++) begin
      vld_in[s]  = vld_q[s-1];
      rem_in[s]  = rem_q[s-1];
      num_in[s]  = num_q[s-1];
      den_in[s]  = den_q[s-1];
      dbl_in[s]  = dbl_q[s-1];
      zero_in[s] = zero_q[s-1];
      side_in[s] = side_q[s-1];
    end
    for (int s = 0; s < N; s++) begin
      shifted[s] = {rem_in[s], num_in[s][31]};
      trial[s]   = shifted[s] - {1'b0, den_in[s]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < N; s++) begin
        if (!trial[s][32]) begin
          rem_q[s] <= trial[s][31:0];
          num_q[s] <= {num_in[s][30:0], 1'b1};
        end else begin
          rem_q[s] <= shifted[s][31:0];
          num_q[s] <= {num_in[s][30:0], 1'b0};
        end
        den_q[s]  <= den_in[s];
        side_q[s] <= side_in[s];
      end
      dbl_q  <= dbl_in;
      zero_q <= zero_in;
    end
  end

  assign valid_o = vld_q[N-1];
  assign quo_o   = num_q[N-1];
  assign dbl_o   = dbl_q[N-1];
  assign zero_o  = zero_q[N-1];
  assign side_o  = side_q[N-1];
endmodule
`default_nettype wire

/* hw/rtl/stc_datapath.sv */
// stc_datapath: pipelined compensation arithmetic with global stall enable.
// Depends on stc_pkg and stc_divider.
`default_nettype none
module stc_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire stc_pkg::in_t    in_i,
  input  wire stc_pkg::trim_t  trim_i,
  output logic                 valid_o,
  output stc_pkg::out_t        out_o
);
  import stc_pkg::*;

  localparam int unsigned NS = 12;  // stages before the divider
  logic [NS:1] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[NS-1:1], valid_i};
  end

  trim_t tr;
  assign tr = trim_i;

  // stage 1: temperature products
  logic [31:0] s1_m1, s1_dd, s1_ap, s1_ah;
  always_ff @(posedge clk_i) if (en_i) begin
    s1_m1 <= mul({15'd0, in_i.raw_temperature[19:3]} - (tr.t1 << 1), tr.t2);
    s1_dd <= mul({16'd0, in_i.raw_temperature[19:4]} - tr.t1,
                 {16'd0, in_i.raw_temperature[19:4]} - tr.t1);
    s1_ap <= {12'd0, in_i.raw_pressure};
    s1_ah <= {16'd0, in_i.raw_humidity};
  end

  // stage 2
  logic [31:0] s2_v1, s2_v2p, s2_ap, s2_ah;
  always_ff @(posedge clk_i) if (en_i) begin
    s2_v1  <= asr(s1_m1, 11);
    s2_v2p <= mul(asr(s1_dd, 12), tr.t3);
    s2_ap  <= s1_ap;
    s2_ah  <= s1_ah;
  end

  // stage 3: fine temperature
  logic [31:0] s3_tf, s3_ap, s3_ah;
  always_ff @(posedge clk_i) if (en_i) begin
    s3_tf <= s2_v1 + asr(s2_v2p, 14);
    s3_ap <= s2_ap;
    s3_ah <= s2_ah;
  end

  // stage 4: temperature result, pressure v1, humidity x
  logic [31:0] s4_tf, s4_temp, s4_pv1, s4_hx, s4_ap, s4_ah;
  always_ff @(posedge clk_i) if (en_i) begin
    s4_tf   <= s3_tf;
    s4_temp <= asr(mul(s3_tf, 32'd5) + 32'd128, 8);
    s4_pv1  <= asr(s3_tf, 1) - 32'd64000;
    s4_hx   <= s3_tf - 32'd76800;
    s4_ap   <= s3_ap;
    s4_ah   <= s3_ah;
  end

  // stage 5: first products
  logic [31:0] s5_temp, s5_pv1, s5_sq, s5_m5, s5_m2, s5_ap;
  logic [31:0] s5_hx, s5_ha0, s5_hb0, s5_hc0;
  always_ff @(posedge clk_i) if (en_i) begin
    s5_temp <= s4_temp;
    s5_pv1  <= s4_pv1;
    s5_sq   <= mul(asr(s4_pv1, 2), asr(s4_pv1, 2));
    s5_m5   <= mul(s4_pv1, tr.p5);
    s5_m2   <= mul(tr.p2, s4_pv1);
    s5_ap   <= s4_ap;
    s5_hx   <= s4_hx;
    s5_ha0  <= (s4_ah << 14) - (tr.h4 << 20) - mul(tr.h5, s4_hx) + 32'd16384;
    s5_hb0  <= mul(s4_hx, tr.h6);
    s5_hc0  <= mul(s4_hx, tr.h3);
  end

  // stage 6
  logic [31:0] s6_temp, s6_v2, s6_m3, s6_m2, s6_ap, s6_ha, s6_hbc;
  always_ff @(posedge clk_i) if (en_i) begin
    s6_temp <= s5_temp;
    s6_v2   <= mul(asr(s5_sq, 11), tr.p6) + (s5_m5 << 1);
    s6_m3   <= mul(tr.p3, asr(s5_sq, 13));
    s6_m2   <= s5_m2;
    s6_ap   <= s5_ap;
    s6_ha   <= asr(s5_ha0, 15);
    s6_hbc  <= mul(asr(s5_hb0, 10), asr(s5_hc0, 11) + 32'd32768);
  end

  // stage 7
  logic [31:0] s7_temp, s7_v2, s7_v1, s7_ap, s7_ha, s7_hd;
  always_ff @(posedge clk_i) if (en_i) begin
    s7_temp <= s6_temp;
    s7_v2   <= asr(s6_v2, 2) + (tr.p4 << 16);
    s7_v1   <= asr(asr(s6_m3, 3) + asr(s6_m2, 1), 18);
    s7_ap   <= s6_ap;
    s7_ha   <= s6_ha;
    s7_hd   <= mul(asr(s6_hbc, 10) + 32'd2097152, tr.h2);
  end

  // stage 8: divisor, dividend product, humidity product
  logic [31:0] s8_temp, s8_den, s8_pm, s8_hx;
  always_ff @(posedge clk_i) if (en_i) begin
    s8_temp <= s7_temp;
    s8_den  <= mul(32'd32768 + s7_v1, tr.p1);
    s8_pm   <= mul((32'd1048576 - s7_ap) - asr(s7_v2, 12), 32'd3125);
    s8_hx   <= mul(s7_ha, asr(s7_hd + 32'd8192, 14));
  end

  // stage 9
  logic [31:0] s9_temp, s9_den, s9_pm, s9_hx, s9_hsq;
  always_ff @(posedge clk_i) if (en_i) begin
    s9_temp <= s8_temp;
    s9_den  <= asr(s8_den, 15);
    s9_pm   <= s8_pm;
    s9_hx   <= s8_hx;
    s9_hsq  <= mul(asr(s8_hx, 15), asr(s8_hx, 15));
  end

  // stage 10
  logic [31:0] s10_temp, s10_den, s10_pm, s10_hx, s10_hm;
  always_ff @(posedge clk_i) if (en_i) begin
    s10_temp <= s9_temp;
    s10_den  <= s9_den;
    s10_pm   <= s9_pm;
    s10_hx   <= s9_hx;
    s10_hm   <= mul(asr(s9_hsq, 7), tr.h1);
  end

  // stage 11: humidity clamp
  logic [31:0] s11_temp, s11_den, s11_pm, hx_sub, hx_cl;
  logic [16:0] s11_hum;
  always_comb begin
    hx_sub = s10_hx - asr(s10_hm, 4);
    hx_cl  = hx_sub;
    if (hx_sub[31])           hx_cl = '0;
    else if (hx_sub > HumMax) hx_cl = HumMax;
  end
  always_ff @(posedge clk_i) if (en_i) begin
    s11_temp <= s10_temp;
    s11_den  <= s10_den;
    s11_pm   <= s10_pm;
    s11_hum  <= hx_cl[28:12];
  end

  // stage 12: set up dividend
  logic [31:0] s12_num, s12_den;
  logic        s12_dbl, s12_zero;
  out_t        s12_side;
  always_ff @(posedge clk_i) if (en_i) begin
    s12_dbl              <= s11_pm[31];
    s12_num              <= s11_pm[31] ? s11_pm : (s11_pm << 1);
    s12_den              <= s11_den;
    s12_zero             <= (s11_den == '0);
    s12_side.temperature <= s11_temp;
    s12_side.pressure    <= '0;
    s12_side.humidity    <= s11_hum;
  end

  logic        dv_valid, dv_dbl, dv_zero;
  logic [31:0] dv_quo;
  out_t        dv_side;
  stc_divider u_div (
    .clk_i, .rst_ni, .en_i,
    .valid_i(v_q[NS]), .num_i(s12_num), .den_i(s12_den),
    .dbl_i(s12_dbl), .zero_i(s12_zero), .side_i(s12_side),
    .valid_o(dv_valid), .quo_o(dv_quo), .dbl_o(dv_dbl), .zero_o(dv_zero),
    .side_o(dv_side)
  );

  // post stage A: p and its products
  logic        pa_v, pa_zero;
  logic [31:0] pa_p, pa_sq, pa_b;
  out_t        pa_side;
  logic [31:0] p_w;
  assign p_w = dv_dbl ? (dv_quo << 1) : dv_quo;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pa_v <= 1'b0;
    else if (en_i) pa_v <= dv_valid;
  end
  always_ff @(posedge clk_i) if (en_i) begin
    pa_zero <= dv_zero;
    pa_p    <= p_w;
    pa_sq   <= mul(p_w >> 3, p_w >> 3);
    pa_b    <= asr(mul(p_w >> 2, tr.p8), 13);
    pa_side <= dv_side;
  end

  // post stage B
  logic        pb_v, pb_zero;
  logic [31:0] pb_p, pb_a, pb_b;
  out_t        pb_side;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pb_v <= 1'b0;
    else if (en_i) pb_v <= pa_v;
  end
  always_ff @(posedge clk_i) if (en_i) begin
    pb_zero <= pa_zero;
    pb_p    <= pa_p;
    pb_a    <= asr(mul(tr.p9, pa_sq >> 13), 12);
    pb_b    <= pa_b;
    pb_side <= pa_side;
  end

  // post stage C: final pressure
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (en_i) valid_o <= pb_v;
  end
  always_ff @(posedge clk_i) if (en_i) begin
    out_o.temperature <= pb_side.temperature;
    out_o.humidity    <= pb_side.humidity;
    out_o.pressure    <= pb_zero ? 32'd0 : pb_p + asr(pb_a + pb_b + tr.p7, 4);
  end
endmodule
`default_nettype wire

/* hw/rtl/stc_checker.sv */
// stc_checker: port-level checks on the trim compensation block, bound to top.
// Depends on stc_pkg.
`default_nettype none
module stc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire stc_pkg::out_t out_data
);
  import stc_pkg::*;

  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready) else $error("ready while stalled");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed under stall");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.humidity <= 17'd102400) else $error("humidity range");

  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("not ready while empty");
endmodule

bind sensor_trim_compensation stc_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
`default_nettype wire

/* dv/tb.sv */
// Testbench for sensor_trim_compensation: drives raw reading words and trim
// register writes, predicts each compensated word and checks the output stream.
// Depends on stc_pkg, stc_stream_if and the block's RTL.
`default_nettype none
module tb;
  import stc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PipeLat = 47;
  localparam longint unsigned MaxCycles = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  stc_stream_if #(.T(in_t))  in_if  (.clk_i(clk_i));
  stc_stream_if #(.T(out_t)) out_if (.clk_i(clk_i));

  sensor_trim_compensation dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if.sink), .out_if(out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // trim shadow
  logic [47:0] trim_temp;
  logic [63:0] trim_pa, trim_pb;
  logic [15:0] trim_pc;
  logic [39:0] trim_ha;
  logic [31:0] trim_hb;

  out_t comp_q[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off = 0;
  longint unsigned cycle_cnt = 0;

  function automatic logic [31:0] sra(logic [31:0] x, int n);
    sra = 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] ext16(logic [15:0] v);
    ext16 = {{16{v[15]}}, v};
  endfunction

  function automatic out_t compensate(in_t w);
    logic [31:0] at, ap, ah, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] v1, v2, d, tf, sq, p, x, a, b, c, e;
    out_t r;
    at = 32'(w.raw_temperature);
    ap = 32'(w.raw_pressure);
    ah = 32'(w.raw_humidity);
    t1 = 32'(trim_temp[15:0]);
    t2 = ext16(trim_temp[31:16]);
    t3 = ext16(trim_temp[47:32]);
    p1 = 32'(trim_pa[15:0]);
    p2 = ext16(trim_pa[31:16]);
    p3 = ext16(trim_pa[47:32]);
    p4 = ext16(trim_pa[63:48]);
    p5 = ext16(trim_pb[15:0]);
    p6 = ext16(trim_pb[31:16]);
    p7 = ext16(trim_pb[47:32]);
    p8 = ext16(trim_pb[63:48]);
    p9 = ext16(trim_pc);
    h1 = 32'(trim_ha[7:0]);
    h2 = ext16(trim_ha[23:8]);
    h3 = 32'(trim_ha[31:24]);
    h6 = {{24{trim_ha[39]}}, trim_ha[39:32]};
    h4 = ext16(trim_hb[15:0]);
    h5 = ext16(trim_hb[31:16]);

    v1 = sra(((at >> 3) - (t1 << 1)) * t2, 11);
    d = (at >> 4) - t1;
    v2 = sra(sra(d * d, 12) * t3, 14);
    tf = v1 + v2;
    r.temperature = sra(tf * 32'd5 + 32'd128, 8);

    v1 = sra(tf, 1) - 32'd64000;
    sq = sra(v1, 2) * sra(v1, 2);
    v2 = sra(sq, 11) * p6;
    v2 = v2 + ((v1 * p5) << 1);
    v2 = sra(v2, 2) + (p4 << 16);
    v1 = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * v1, 1), 18);
    v1 = sra((32'd32768 + v1) * p1, 15);
    if (v1 == 0) begin
      r.pressure = '0;
    end else begin
      p = ((32'd1048576 - ap) - sra(v2, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / v1;
      else p = (p / v1) * 32'd2;
      a = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      b = sra((p >> 2) * p8, 13);
      r.pressure = p + sra(a + b + p7, 4);
    end

    x = tf - 32'd76800;
    a = sra((ah << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    b = sra(x * h6, 10);
    c = sra(x * h3, 11) + 32'd32768;
    d = sra(b * c, 10) + 32'd2097152;
    e = sra(d * h2 + 32'd8192, 14);
    x = a * e;
    x = x - sra(sra(sra(x, 15) * sra(x, 15), 7) * h1, 4);
    if (x[31]) x = '0;
    if (x > HumMax) x = HumMax;
    r.humidity = 17'(x >> 12);
    return r;
  endfunction

  task automatic write_trim(reg_idx_e idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_CAL_TEMP:    trim_temp = val[47:0];
      REG_CAL_PRESS_A: trim_pa = val;
      REG_CAL_PRESS_B: trim_pb = val;
      REG_CAL_PRESS_C: trim_pc = val[15:0];
      REG_CAL_HUM_A:   trim_ha = val[39:0];
      REG_CAL_HUM_B:   trim_hb = val[31:0];
      default: ;
    endcase
  endtask

  // typical trim set, so readings land in a meaningful range
  task automatic load_typical_trim();
    write_trim(REG_CAL_TEMP, {16'hFC18, 16'd26435, 16'd27504});
    write_trim(REG_CAL_PRESS_A, {16'd2855, 16'hF5F8, 16'hD5B5, 16'd36477});
    write_trim(REG_CAL_PRESS_B, {16'hC0B8, 16'd15500, 16'hFFF9, 16'd140});
    write_trim(REG_CAL_PRESS_C, 64'd6000);
    write_trim(REG_CAL_HUM_A, {8'd30, 8'd0, 16'd360, 8'd75});
    write_trim(REG_CAL_HUM_B, {16'd50, 16'd340});
  endtask

  task automatic load_random_trim();
    write_trim(REG_CAL_TEMP, {$urandom, $urandom});
    write_trim(REG_CAL_PRESS_A, {$urandom, $urandom});
    write_trim(REG_CAL_PRESS_B, {$urandom, $urandom});
    write_trim(REG_CAL_PRESS_C, {$urandom, $urandom});
    write_trim(REG_CAL_HUM_A, {$urandom, $urandom});
    write_trim(REG_CAL_HUM_B, {$urandom, $urandom});
  endtask

  task automatic load_uniform_trim(logic [63:0] v);
    write_trim(REG_CAL_TEMP, v);
    write_trim(REG_CAL_PRESS_A, v);
    write_trim(REG_CAL_PRESS_B, v);
    write_trim(REG_CAL_PRESS_C, v);
    write_trim(REG_CAL_HUM_A, v);
    write_trim(REG_CAL_HUM_B, v);
  endtask

  // drive one word; called and returns at a falling edge, valid left high
  // so the next word can follow at once
  task automatic send_reading(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    in_t w;
    w.raw_temperature = rt;
    w.raw_pressure = rp;
    w.raw_humidity = rh;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= w;
    do @(posedge clk_i); while (!in_if.ready);
    comp_q.push_back(compensate(w));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (comp_q.size() != 0) @(negedge clk_i);
    repeat (PipeLat + 5) @(negedge clk_i);
  endtask

  function automatic logic [19:0] rand_raw20();
    case ($urandom_range(3, 0))
      0: rand_raw20 = 20'(440000 + $urandom_range(180000, 0));
      1: rand_raw20 = $urandom_range(1, 0) ? 20'hFFFFF : 20'h0;
      default: rand_raw20 = 20'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    load_uniform_trim('0);
    send_reading(20'h0, 20'h0, 16'h0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    drain();
    load_uniform_trim('1);
    send_reading(20'h0, 20'hFFFFF, 16'h0);
    send_reading(20'hFFFFF, 20'h0, 16'hFFFF);
    send_reading(20'h80000, 20'h80000, 16'h8000);
    drain();
    load_uniform_trim({4{16'h8000}});
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_reading(20'h0, 20'h0, 16'h0);
    drain();
    load_uniform_trim({4{16'h7FFF}});
    send_reading(20'hFFFFF, 20'h0, 16'hFFFF);
    send_reading(20'h0, 20'hFFFFF, 16'h0);
    drain();
  endtask

  // zero P1 gives a zero pressure divisor; humidity driven to both clamps
  task automatic test_special_cases();
    load_typical_trim();
    send_reading(20'd519888, 20'd415148, 16'd30000);
    send_reading(20'd519888, 20'd415148, 16'hFFFF);
    send_reading(20'd519888, 20'd415148, 16'h0);
    send_reading(20'd400000, 20'd300000, 16'd50000);
    drain();
    write_trim(REG_CAL_PRESS_A, {16'd2855, 16'hF5F8, 16'hD5B5, 16'd0});
    send_reading(20'd519888, 20'd415148, 16'd30000);
    send_reading(20'd600000, 20'hFFFFF, 16'd1000);
    drain();
    write_trim(REG_CAL_HUM_B, {16'h8000, 16'h8000});
    send_reading(20'd519888, 20'd415148, 16'hFFFF);
    drain();
    write_trim(REG_CAL_HUM_B, {16'h7FFF, 16'h7FFF});
    send_reading(20'd519888, 20'd415148, 16'h0);
    drain();
  endtask

  task automatic test_random(int unsigned n, bit typical);
    if (typical) load_typical_trim();
    else load_random_trim();
    repeat (n) send_reading(rand_raw20(), rand_raw20(), 16'($urandom));
    drain();
  endtask

  task automatic test_backpressure();
    load_typical_trim();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 200;
    repeat (120) send_reading(rand_raw20(), rand_raw20(), 16'($urandom));
    drain();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    trim_temp = '0;
    trim_pa = '0;
    trim_pb = '0;
    trim_pc = '0;
    trim_ha = '0;
    trim_hb = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // reset trim is all zero
    send_reading(20'd519888, 20'd415148, 16'd30000);
    drain();
    test_extremes();
    test_special_cases();
    test_backpressure();
    send_idle_pct = 0;   recv_stall_pct = 0;  test_random(350, 1'b1);
    send_idle_pct = 74;  recv_stall_pct = 0;  test_random(350, 1'b0);
    send_idle_pct = 0;   recv_stall_pct = 74; test_random(350, 1'b1);
    send_idle_pct = 7;   recv_stall_pct = 7;  test_random(350, 1'b0);
    send_idle_pct = 0;   recv_stall_pct = 0;  test_random(300, 1'b1);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver ready; held low while a requested hold-off counts down to zero
  always @(negedge clk_i) begin
    if (hold_off != 0) begin
      out_if.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    out_t exp_w;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycles) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (comp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", out_if.data);
      end else begin
        exp_w = comp_q.pop_front();
        if (out_if.data.temperature !== exp_w.temperature ||
            out_if.data.pressure !== exp_w.pressure ||
            out_if.data.humidity !== exp_w.humidity) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp T=%0d P=%0d H=%0d got T=%0d P=%0d H=%0d",
                     exp_w.temperature, exp_w.pressure, exp_w.humidity,
                     out_if.data.temperature, out_if.data.pressure,
                     out_if.data.humidity);
        end
      end
    end
  end
endmodule
`default_nettype wire

/* sim.f */
hw/rtl/stc_pkg.sv
hw/rtl/stc_stream_if.sv
hw/rtl/stc_cfg_regs.sv
hw/rtl/stc_divider.sv
hw/rtl/stc_datapath.sv
hw/rtl/sensor_trim_compensation.sv
hw/rtl/stc_checker.sv
dv/tb.sv
